// ===== hdl/actr_pkg.sv =====
// Package for the AES-128 counter-mode block: payload word types, S-box and AES helpers.
// Used by every module in hdl; depends on nothing.
package actr_pkg;

	localparam int unsigned NumRounds = 10;
	localparam int unsigned BlkBytes  = 16;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_NONCE    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] block_index;
		logic [63:0] data_low;
		logic [63:0] data_high;
		logic [4:0]  byte_count;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result_low;
		logic [63:0] result_high;
	} out_word_t;

	// Data and mask that travel beside the cipher state.
	typedef struct packed {
		logic [127:0] data;
		logic [15:0]  mask;
	} side_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		case (a)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		case (r)
			4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
			4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
			4'd9: v = 8'h1b; 4'd10: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a block sits at bits 8*i+7:8*i.
	function automatic logic [7:0] byte_of(input logic [127:0] b, input int i);
		return b[8*i +: 8];
	endfunction

	// Next round key from the previous one.
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [3:0] r);
		logic [127:0] n;
		logic [31:0]  t;
		t = {sbox(byte_of(k, 12)), sbox(byte_of(k, 15)), sbox(byte_of(k, 14)),
			sbox(byte_of(k, 13)) ^ rcon(r)};
		n[31:0]   = k[31:0]   ^ t;
		n[63:32]  = k[63:32]  ^ n[31:0];
		n[95:64]  = k[95:64]  ^ n[63:32];
		n[127:96] = k[127:96] ^ n[95:64];
		return n;
	endfunction

	// One cipher round; the last round skips MixColumns.
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
			input logic last);
		logic [127:0] t;
		logic [127:0] m;
		logic [7:0]   a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[8*(i+4*c) +: 8] = sbox(byte_of(s, i + 4*((c + i) % 4)));
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[8*(4*c) +: 8];
			a1 = t[8*(4*c+1) +: 8];
			a2 = t[8*(4*c+2) +: 8];
			a3 = t[8*(4*c+3) +: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			m[8*(4*c) +: 8]   = a0 ^ all ^ xtime(a0 ^ a1);
			m[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			m[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			m[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return (last ? t : m) ^ rk;
	endfunction

endpackage

// ===== hdl/aes_ctr_block_crypt.sv =====
// AES-128 counter-mode block crypt; top level with APB registers and the round pipeline.
// Depends on actr_pkg and actr_round.
//
// Usage: write key_low (0x00), key_high (0x08) and nonce (0x10) over the APB
// port while the block is idle. Raise start with a word on in_word; a word is
// taken at every edge where start is high and busy is low. busy is always low,
// so a word may enter every cycle and throughput is one word per cycle.
// There are twelve register stages: one for the counter block and initial key
// addition, ten for the unrolled round stages, and one for keystream XOR and
// byte masking. The first stage loads at the accepting edge; done and out_word
// are registered together from the last round stage. done is high for exactly one
// cycle with the result on out_word; the receiver cannot stall, so no storage
// beyond the pipeline is needed. Reset clears all valid bits and the key and
// nonce registers to zero. The round key is computed alongside each item, so
// each stage carries its own key copy.
module aes_ctr_block_crypt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready,
	input  logic                  start,
	output logic                  busy,
	input  actr_pkg::in_word_t    in_word,
	output logic                  done,
	output actr_pkg::out_word_t   out_word
);
	import actr_pkg::*;

	logic [63:0] key_low_q, key_high_q, nonce_q;
	logic [1:0]  reg_sel;
	logic        wr_en;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_sel = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && (paddr[2:0] == 3'd0);

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			nonce_q    <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_KEY_LOW:  key_low_q  <= pwdata;
				REG_KEY_HIGH: key_high_q <= pwdata;
				REG_NONCE:    nonce_q    <= pwdata;
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (reg_sel)
			REG_KEY_LOW:  prdata = key_low_q;
			REG_KEY_HIGH: prdata = key_high_q;
			REG_NONCE:    prdata = nonce_q;
			default:      prdata = '0;
		endcase
	end

	// Stage 0: counter block, initial key addition and byte mask.
	logic         vld_s0;
	logic [127:0] state_s0, key_s0;
	side_t        side_s0;
	logic [4:0]   cnt;
	logic [15:0]  mask;

	always_comb begin
		cnt = (in_word.byte_count > 5'(BlkBytes)) ? 5'(BlkBytes) : in_word.byte_count;
		for (int i = 0; i < 16; i++) mask[i] = (5'(i) < cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s0 <= 1'b0;
		else vld_s0 <= start;
	end

	always_ff @(posedge clk) begin
		key_s0       <= {key_high_q, key_low_q};
		state_s0     <= {32'd0, in_word.block_index, nonce_q} ^ {key_high_q, key_low_q};
		side_s0.data <= {in_word.data_high, in_word.data_low};
		side_s0.mask <= mask;
	end

	// Rounds one to ten.
	logic         vld_r   [0:NumRounds];
	logic [127:0] state_r [0:NumRounds];
	logic [127:0] key_r   [0:NumRounds];
	side_t        side_r  [0:NumRounds];

	assign vld_r[0]   = vld_s0;
	assign state_r[0] = state_s0;
	assign key_r[0]   = key_s0;
	assign side_r[0]  = side_s0;

	for (genvar g = 1; g <= NumRounds; g++) begin : g_round
		actr_round #(.ROUND(4'(g))) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.vld_in    (vld_r[g-1]),
			.state_in  (state_r[g-1]),
			.key_in    (key_r[g-1]),
			.side_in   (side_r[g-1]),
			.vld_out   (vld_r[g]),
			.state_out (state_r[g]),
			.key_out   (key_r[g]),
			.side_out  (side_r[g])
		);
	end

	// Final stage: keystream XOR and masking of bytes past the count.
	logic [127:0] res;
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			res[8*i +: 8] = side_r[NumRounds].mask[i] ?
				(state_r[NumRounds][8*i +: 8] ^ side_r[NumRounds].data[8*i +: 8]) : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_r[NumRounds];
	end

	always_ff @(posedge clk) begin
		out_word.result_low  <= res[63:0];
		out_word.result_high <= res[127:64];
	end
endmodule

// ===== hdl/actr_round.sv =====
// One pipeline stage of the cipher: an AES round plus the matching key schedule step.
// Depends on actr_pkg.
module actr_round #(
	parameter logic [3:0] ROUND = 4'd1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_in,
	input  logic [127:0]        state_in,
	input  logic [127:0]        key_in,
	input  actr_pkg::side_t     side_in,
	output logic                vld_out,
	output logic [127:0]        state_out,
	output logic [127:0]        key_out,
	output actr_pkg::side_t     side_out
);
	import actr_pkg::*;

	logic [127:0] rk;

	// Round key for this round.
	assign rk = next_key(key_in, ROUND);

	// Valid travels with the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else vld_out <= vld_in;
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		state_out <= aes_round(state_in, rk, ROUND == 4'(NumRounds));
		key_out   <= rk;
		side_out  <= side_in;
	end
endmodule
